### rtl/core/idbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbw_pkg
// Types and constants shared by the display byte writer core: the bus symbol
// codes, the symbol record and the positions of the transaction's parts.
// ----------------------------------------------------------------------------
package idbw_pkg;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BIT   = 2'd1,
      KIND_ACK   = 2'd2,
      KIND_STOP  = 2'd3
   } symbol_kind_type;

   typedef struct packed {
      symbol_kind_type kind;
      logic            bit_value;
      logic            last;
   } symbol_type;

   localparam logic [7:0] ADDR_RESET   = 8'h78;
   localparam logic [7:0] CTRL_DATA    = 8'h40;
   localparam logic [7:0] CTRL_COMMAND = 8'h00;
   localparam logic [7:0] MSB_MASK     = 8'h80;

   localparam int SYMBOLS_PER_ITEM = 29;
   localparam int IDX_W            = $clog2(SYMBOLS_PER_ITEM);

   typedef logic [IDX_W-1:0] idx_type;

   // First symbol index of each byte and of the stop.
   localparam idx_type ADDR_FIRST = idx_type'(1);
   localparam idx_type CTRL_FIRST = idx_type'(10);
   localparam idx_type DATA_FIRST = idx_type'(19);
   localparam idx_type STOP_IDX   = idx_type'(SYMBOLS_PER_ITEM - 1);

   // Offset within a byte at which the acknowledge clock is sent.
   localparam logic [3:0] ACK_OFFSET = 4'd8;

endpackage

### rtl/core/idbw_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbw channels
// Valid/ready channel interfaces for the request, response and register
// write ports of the display byte writer core.
// ----------------------------------------------------------------------------
interface idbw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_data;

   modport source (output valid, output data_byte, output is_data, input ready);
   modport sink   (input valid, input data_byte, input is_data, output ready);
endinterface

interface idbw_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] symbol_kind;
   logic       bit_value;
   logic       last;

   modport source (output valid, output symbol_kind, output bit_value, output last,
                   input ready);
   modport sink   (input valid, input symbol_kind, input bit_value, input last,
                   output ready);
endinterface

interface idbw_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] slave_address_byte;

   modport source (output valid, output slave_address_byte, input ready);
   modport sink   (input valid, input slave_address_byte, output ready);
endinterface

### rtl/core/i2c_display_byte_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_display_byte_writer_core
// Expands each display byte into the symbol stream of one I2C write
// transaction: start, address byte, control byte, payload byte, stop.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one display byte and its data/command flag per transfer.
//   rsp_if delivers 29 bus symbols per request: a start, three bytes of eight
//   bit clocks and one acknowledge clock each, then a stop flagged by last.
//   csr_if writes the address byte (write bit included) sent after the start;
//   it is always ready and should only be written while the core is idle.
// A request passes the pending and the active register; its first symbol is
//   then registered in the output register.
// Throughput: one symbol per cycle while rsp_if.ready is held high, the
//   symbol counter stepping through the transaction.
// One request is held in a pending register while the previous transaction
//   is still being sent, so the next request is taken without a gap.
// A stall on rsp_if holds the current symbol in the output register and
//   freezes the symbol counter; nothing is lost or repeated.
// Reset clears all valid flags and the counter and loads address byte 0x78.
// ----------------------------------------------------------------------------
module i2c_display_byte_writer_core
   import idbw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   idbw_req_if.sink   req_if,
   idbw_rsp_if.source rsp_if,
   idbw_csr_if.sink   csr_if
);

   logic [7:0] slave_addr_ff;

   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_data_ff,  pend_data_in;
   logic       pend_is_data_ff, pend_is_data_in;

   logic       act_valid_ff, act_valid_in;
   logic [7:0] act_data_ff,  act_data_in;
   logic       act_is_data_ff, act_is_data_in;
   idx_type    idx_ff, idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   symbol_type rsp_sym_ff, rsp_sym_in;

   symbol_type gen_sym;
   logic       out_free;
   logic       step;
   logic       finish;
   logic       req_fire;
   logic       load;

   // Register write port.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= ADDR_RESET;
      end else if (csr_if.valid) begin
         slave_addr_ff <= csr_if.slave_address_byte;
      end
   end

   // Handshake control.
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign step         = act_valid_ff && out_free;
   assign finish       = step && (idx_ff == STOP_IDX);
   assign req_if.ready = !pend_valid_ff;
   assign req_fire     = req_if.valid && !pend_valid_ff;
   assign load         = (!act_valid_ff || finish) && pend_valid_ff;

   idbw_symbol_gen u_symbol_gen (
      .idx                (idx_ff),
      .slave_address_byte (slave_addr_ff),
      .is_data            (act_is_data_ff),
      .data_byte          (act_data_ff),
      .symbol             (gen_sym)
   );

   always_comb begin
      pend_valid_in   = pend_valid_ff;
      pend_data_in    = pend_data_ff;
      pend_is_data_in = pend_is_data_ff;
      if (req_fire) begin
         pend_valid_in   = 1'b1;
         pend_data_in    = req_if.data_byte;
         pend_is_data_in = req_if.is_data;
      end else if (load) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      act_valid_in   = act_valid_ff;
      act_data_in    = act_data_ff;
      act_is_data_in = act_is_data_ff;
      idx_in         = idx_ff;
      if (load) begin
         act_valid_in   = 1'b1;
         act_data_in    = pend_data_ff;
         act_is_data_in = pend_is_data_ff;
         idx_in         = '0;
      end else if (finish) begin
         act_valid_in = 1'b0;
         idx_in       = '0;
      end else if (step) begin
         idx_in = idx_ff + idx_type'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sym_in   = rsp_sym_ff;
      if (out_free) begin
         rsp_valid_in = step;
         rsp_sym_in   = gen_sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         act_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         act_valid_ff  <= act_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_data_ff    <= pend_data_in;
      pend_is_data_ff <= pend_is_data_in;
      act_data_ff     <= act_data_in;
      act_is_data_ff  <= act_is_data_in;
      rsp_sym_ff      <= rsp_sym_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.symbol_kind = rsp_sym_ff.kind;
   assign rsp_if.bit_value   = rsp_sym_ff.bit_value;
   assign rsp_if.last        = rsp_sym_ff.last;

endmodule

### rtl/core/idbw_symbol_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbw_symbol_gen
// Decodes a symbol index within one write transaction into the bus symbol
// sent at that position.
// ----------------------------------------------------------------------------
module idbw_symbol_gen
   import idbw_pkg::*;
(
   input  idx_type    idx,
   input  logic [7:0] slave_address_byte,
   input  logic       is_data,
   input  logic [7:0] data_byte,
   output symbol_type symbol
);

   logic [7:0]       cur_byte;
   logic [IDX_W-1:0] offset_wide;
   logic [3:0]       offset;
   logic             in_byte;
   logic [7:0]       shifted;

   always_comb begin
      cur_byte    = data_byte;
      offset_wide = '0;
      in_byte     = 1'b1;
      priority if (idx < ADDR_FIRST) begin
         in_byte = 1'b0;
      end else if (idx < CTRL_FIRST) begin
         cur_byte    = slave_address_byte;
         offset_wide = idx - ADDR_FIRST;
      end else if (idx < DATA_FIRST) begin
         cur_byte    = is_data ? CTRL_DATA : CTRL_COMMAND;
         offset_wide = idx - CTRL_FIRST;
      end else if (idx < STOP_IDX) begin
         cur_byte    = data_byte;
         offset_wide = idx - DATA_FIRST;
      end else begin
         in_byte = 1'b0;
      end
   end

   assign offset  = offset_wide[3:0];
   assign shifted = cur_byte << offset[2:0];

   always_comb begin
      symbol.bit_value = 1'b0;
      symbol.last      = 1'b0;
      if (!in_byte) begin
         if (idx < ADDR_FIRST) begin
            symbol.kind = KIND_START;
         end else begin
            symbol.kind = KIND_STOP;
            symbol.last = 1'b1;
         end
      end else if (offset == ACK_OFFSET) begin
         symbol.kind = KIND_ACK;
      end else begin
         // Bytes go out most significant bit first.
         symbol.kind      = KIND_BIT;
         symbol.bit_value = |(shifted & MSB_MASK);
      end
   end

endmodule

### rtl/core/idbw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbw_checker
// Port-level checks for the display byte writer core, bound to the top level.
// ----------------------------------------------------------------------------
module idbw_checker
   import idbw_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_symbol_kind,
   input logic       rsp_bit_value,
   input logic       rsp_last
);

   // A stalled symbol is held unchanged until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol_kind)
         && $stable(rsp_bit_value) && $stable(rsp_last))
      else $error("stalled response symbol changed");

   // Only the stop symbol closes a transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_symbol_kind == KIND_STOP)
      else $error("last flag on a symbol other than stop");

   // SDA level is only carried by data bit clocks.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_symbol_kind != KIND_BIT |-> !rsp_bit_value)
      else $error("bit value set on a non-data symbol");

   // Nothing is offered straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind i2c_display_byte_writer_core idbw_checker u_idbw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_symbol_kind (rsp_if.symbol_kind),
   .rsp_bit_value   (rsp_if.bit_value),
   .rsp_last        (rsp_if.last)
);

### tb/sv/idbw_symbol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbw_symbol_checker
// Watches the request, register and symbol channels of the display byte
// writer core, builds the symbol stream of each I2C write transaction it
// expects and compares every symbol transfer against the oldest one waiting.
// ----------------------------------------------------------------------------
module idbw_symbol_checker
   import idbw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_symbol_kind,
   input  logic       rsp_bit_value,
   input  logic       rsp_last,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_slave_address_byte,
   output int         mismatch_count,
   output int         symbols_outstanding
);

   localparam int PRINT_LIMIT = 40;

   logic [7:0] address_byte = ADDR_RESET;
   symbol_type expected_symbols[$];
   int mismatches      = 0;
   int symbols_checked = 0;

   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string detail);
      if (mismatches < PRINT_LIMIT)
         $display("%0t ns: symbol %0d: %s", $time, symbols_checked, detail);
      mismatches++;
   endtask

   function automatic symbol_type make_symbol(input symbol_kind_type kind,
                                              input logic bit_value, input logic last);
      symbol_type sym;
      sym.kind      = kind;
      sym.bit_value = bit_value;
      sym.last      = last;
      return sym;
   endfunction

   // Eight bit clocks, most significant bit first, then an acknowledge clock.
   task automatic queue_byte(input logic [7:0] value);
      logic [7:0] shifter;
      shifter = value;
      for (int i = 0; i < 8; i++) begin
         expected_symbols.push_back(make_symbol(KIND_BIT, (shifter & MSB_MASK) != 8'h00,
                                                1'b0));
         shifter = shifter << 1;
      end
      expected_symbols.push_back(make_symbol(KIND_ACK, 1'b0, 1'b0));
   endtask

   task automatic queue_transaction(input logic [7:0] payload, input logic is_data);
      expected_symbols.push_back(make_symbol(KIND_START, 1'b0, 1'b0));
      queue_byte(address_byte);
      queue_byte(is_data ? CTRL_DATA : CTRL_COMMAND);
      queue_byte(payload);
      expected_symbols.push_back(make_symbol(KIND_STOP, 1'b0, 1'b1));
   endtask

   always @(posedge clock) begin : watch
      symbol_type want;
      if (reset) begin
         address_byte = ADDR_RESET;
         expected_symbols.delete();
      end else begin
         // A symbol can never belong to a request taken at the same edge, so
         // the comparison comes before the new transaction is queued.
         if (rsp_valid && rsp_ready) begin
            if (expected_symbols.size() == 0) begin
               report_mismatch($sformatf("unexpected symbol, kind %0d", rsp_symbol_kind));
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_symbol_kind !== want.kind)
                  report_mismatch($sformatf("symbol_kind %0d, expected %0d",
                                            rsp_symbol_kind, want.kind));
               if (rsp_bit_value !== want.bit_value)
                  report_mismatch($sformatf("bit_value %0b, expected %0b",
                                            rsp_bit_value, want.bit_value));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
            end
            symbols_checked++;
         end
         if (csr_valid && csr_ready)
            address_byte = csr_slave_address_byte;
         if (req_valid && req_ready)
            queue_transaction(req_data_byte, req_is_data);
      end
      symbols_outstanding <= expected_symbols.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the display byte writer core with directed and random display bytes
// over several address settings, with random gaps on the request side and
// random back-pressure on the symbol side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RUN_LIMIT_NS  = 12_000_000;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 47;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   symbols_outstanding;

   idbw_req_if req_if ();
   idbw_rsp_if rsp_if ();
   idbw_csr_if csr_if ();

   i2c_display_byte_writer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   idbw_symbol_checker symbol_check (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_if.valid),
      .req_ready              (req_if.ready),
      .req_data_byte          (req_if.data_byte),
      .req_is_data            (req_if.is_data),
      .rsp_valid              (rsp_if.valid),
      .rsp_ready              (rsp_if.ready),
      .rsp_symbol_kind        (rsp_if.symbol_kind),
      .rsp_bit_value          (rsp_if.bit_value),
      .rsp_last               (rsp_if.last),
      .csr_valid              (csr_if.valid),
      .csr_ready              (csr_if.ready),
      .csr_slave_address_byte (csr_if.slave_address_byte),
      .mismatch_count         (mismatch_count),
      .symbols_outstanding    (symbols_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("i2c_display_byte_writer_core regression: fail");
      $finish;
   end

   // Symbol side: runs of ready, mostly short, now and then a long stretch
   // without stalls, separated by gaps that are mostly short and a few long.
   initial begin : symbol_backpressure
      int run_len;
      int gap_len;
      int pick;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         pick    = $urandom_range(0, 19);
         run_len = (pick == 0) ? $urandom_range(60, 200) : $urandom_range(1, 8);
         rsp_if.ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         pick = $urandom_range(0, 19);
         if (pick < 6)
            gap_len = 0;
         else if (pick < 19)
            gap_len = $urandom_range(1, 3);
         else
            gap_len = $urandom_range(10, 40);
         if (gap_len > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
   end

   // Valid stays high into the next byte when no gap is drawn.
   task automatic send_display_byte(input logic [7:0] payload, input logic is_data);
      int pick;
      int gap_len;
      req_if.valid     <= 1'b1;
      req_if.data_byte <= payload;
      req_if.is_data   <= is_data;
      do @(posedge clock); while (!req_if.ready);
      pick = $urandom_range(0, 19);
      if (pick < 11)
         gap_len = 0;
      else if (pick < 18)
         gap_len = $urandom_range(1, 4);
      else
         gap_len = $urandom_range(20, 80);
      if (gap_len > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
   endtask

   task automatic write_address_byte(input logic [7:0] value);
      csr_if.valid              <= 1'b1;
      csr_if.slave_address_byte <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // The core is idle once every symbol of every accepted byte has been seen.
   task automatic drain_transactions();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (symbols_outstanding != 0);
   endtask

   initial begin : stimulus
      logic [7:0] address;
      req_if.valid              = 1'b0;
      req_if.data_byte          = 8'h00;
      req_if.is_data            = 1'b0;
      csr_if.valid              = 1'b0;
      csr_if.slave_address_byte = 8'h00;
      reset                     = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The address byte left by reset, with payload and flag extremes.
      send_display_byte(8'h00, 1'b0);
      send_display_byte(8'hFF, 1'b1);
      send_display_byte(8'h80, 1'b0);
      send_display_byte(8'h01, 1'b1);
      send_display_byte(8'hA5, 1'b0);
      send_display_byte(8'h5A, 1'b1);
      drain_transactions();

      write_address_byte(8'h00);
      send_display_byte(8'hFF, 1'b1);
      send_display_byte(8'h00, 1'b0);
      drain_transactions();

      write_address_byte(8'hFF);
      send_display_byte(8'h00, 1'b1);
      send_display_byte(8'hFF, 1'b0);
      send_display_byte(8'h55, 1'b1);
      drain_transactions();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            address = 8'h55;
         else if (phase == 1)
            address = 8'hAA;
         else
            address = 8'($urandom_range(0, 255));
         write_address_byte(address);
         repeat (PHASE_ITEMS)
            send_display_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         drain_transactions();
      end

      // Run on after the drain so that any stray symbol after the last stop is seen.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && symbols_outstanding == 0)
         $display("i2c_display_byte_writer_core regression: pass");
      else
         $display("i2c_display_byte_writer_core regression: fail");
      $finish;
   end

endmodule
